### rtl/cpfm_pkg.sv
package cpfm_pkg;

  localparam int TIMER_BITS   = 16;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int FREQ_W       = 20;
  localparam int CNT_W        = $clog2(FREQ_W);
  localparam int DEF_CHANNELS = 2;

  localparam logic [CFG_W-1:0] REF_CLOCK_RST  = 16'd32768;
  localparam logic [CFG_W-1:0] MAX_PERIOD_RST = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic meas_ok;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/cpfm_if.sv
interface cpfm_in_if import cpfm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  channel;
  logic [TIMER_BITS-1:0] timestamp;

  modport source(output valid, channel, timestamp, input ready);
  modport sink(input valid, channel, timestamp, output ready);
endinterface

interface cpfm_out_if import cpfm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  out_channel;
  logic [TIMER_BITS-1:0] period_ticks;
  logic [FREQ_W-1:0]     freq_tenths;
  logic                  valid_res;

  modport source(output valid, out_channel, period_ticks, freq_tenths, valid_res, input ready);
  modport sink(input valid, out_channel, period_ticks, freq_tenths, valid_res, output ready);
endinterface

### rtl/cpfm_ctrl.sv
module cpfm_ctrl import cpfm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.item_ok) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = status.meas_ok ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && status.item_ok;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_DIV:  cmd.step = 1'b1;
      ST_DONE: cmd.publish = !status.out_busy;
      default: ;
    endcase
  end

  a_publish_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> ($past(state) == ST_DONE || $past(state) == ST_DIV
                     || $past(state) == ST_PREP))
    else $error("publish without a finished measurement");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && status.div_last) |=> state == ST_DONE)
    else $error("divider did not hand off");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_PREP)
    else $error("load did not start a measurement");

endmodule

### rtl/cpfm_datapath.sv
module cpfm_datapath import cpfm_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  channel,
  input  logic [TIMER_BITS-1:0] timestamp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  cpfm_out_if.source            meas_out
);

  logic [CFG_W-1:0]      ref_clock_hz;
  logic [CFG_W-1:0]      max_period;
  logic [TIMER_BITS-1:0] last_stamp [CHANNELS];
  logic [TIMER_BITS-1:0] prev_stamp;
  logic                  ch;
  logic [TIMER_BITS-1:0] period;
  logic                  meas_valid;
  logic [FREQ_W-1:0]     quo;
  logic [TIMER_BITS-1:0] rem;
  logic [CNT_W-1:0]      cnt;
  logic [TIMER_BITS:0]   rem_shift;
  logic [TIMER_BITS:0]   diff;
  logic                  ge;
  logic                  out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz <= REF_CLOCK_RST;
      max_period   <= MAX_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_CLOCK:  ref_clock_hz <= cfg_data;
        REG_MAX_PERIOD: max_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_stamp
    always_ff @(posedge clk) begin
      if (rst) begin
        last_stamp[i] <= '0;
      end else if (cmd.load && int'(channel) == i) begin
        last_stamp[i] <= timestamp;
      end
    end
  end

  always_comb begin
    prev_stamp = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(channel) == i) prev_stamp = last_stamp[i];
    end
  end

  // one restoring division step per cycle
  assign rem_shift = {rem, quo[FREQ_W-1]};
  assign diff      = rem_shift - {1'b0, period};
  assign ge        = rem_shift >= {1'b0, period};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch     <= channel;
      period <= timestamp - prev_stamp;
    end
    if (cmd.prep) begin
      meas_valid <= status.meas_ok;
      quo        <= (FREQ_W'(ref_clock_hz) << 3) + (FREQ_W'(ref_clock_hz) << 1);
      rem        <= '0;
      cnt        <= '0;
    end else if (cmd.step) begin
      quo <= {quo[FREQ_W-2:0], ge};
      rem <= ge ? diff[TIMER_BITS-1:0] : rem_shift[TIMER_BITS-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (meas_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      meas_out.out_channel  <= ch;
      meas_out.period_ticks <= period;
      meas_out.freq_tenths  <= meas_valid ? quo : '0;
      meas_out.valid_res    <= meas_valid;
    end
  end

  assign meas_out.valid = out_valid;

  assign status.item_ok  = int'(channel) < CHANNELS;
  assign status.meas_ok  = (period != '0) && (period <= max_period);
  assign status.div_last = cnt == CNT_W'(FREQ_W - 1);
  assign status.out_busy = out_valid && !meas_out.ready;

  a_publish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("result not presented after publish");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !meas_out.valid_res) |-> meas_out.freq_tenths == '0)
    else $error("invalid measurement with nonzero frequency");

  a_valid_period: assert property (@(posedge clk) disable iff (rst)
    (out_valid && meas_out.valid_res) |-> meas_out.period_ticks != '0)
    else $error("valid measurement with zero period");

endmodule

### rtl/capture_period_frequency_meter_core.sv
// an input transaction with an in-range period passes through a setup state, 20 steps
// of the bit-serial divider and an output load, which waits while the last result is not taken
// an out-of-range or zero period skips the divider
// the shared divider takes no new transaction until the previous result is loaded to the output
// reset (synchronous, active high) zeroes the per-channel stamps and loads the registers
module capture_period_frequency_meter_core import cpfm_pkg::*; #(
  parameter int CHANNELS = DEF_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst,
  cpfm_in_if.sink              meas_in,
  cpfm_out_if.source           meas_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  cpfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (meas_in.valid),
    .in_ready (meas_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  cpfm_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .channel   (meas_in.channel),
    .timestamp (meas_in.timestamp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .meas_out  (meas_out)
  );

endmodule
